### rtl/core/prke_pkg.sv
`timescale 1ns / 1ps

package prke_pkg;

   // Round key store
   localparam int MAX_ROUND_KEYS = 32;
   localparam int STORE_AW       = $clog2(MAX_ROUND_KEYS);

   // Byte counter saturates here
   localparam logic [8:0] COUNT_MAX = 9'd511;

   // schedule_mode codes
   localparam logic [1:0] MODE_K80     = 2'd0;
   localparam logic [1:0] MODE_K128    = 2'd1;
   localparam logic [1:0] MODE_INDEP   = 2'd2;
   localparam logic [1:0] MODE_UNKNOWN = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_ROUNDS = 2'd1;
   localparam logic [1:0] CSR_SBOX   = 2'd2;

   // Reset values
   localparam logic [1:0]  MODE_RESET   = MODE_K80;
   localparam logic [4:0]  ROUNDS_RESET = 5'd31;
   localparam logic [63:0] SBOX_RESET   = 64'd2410709909328475740;

   typedef logic [127:0] key_type;

   // One S-box lookup, entry i in bits 4i+3..4i
   function automatic logic [3:0] sbox_lookup(input logic [63:0] tbl, input logic [3:0] x);
      return tbl[{x, 2'b00} +: 4];
   endfunction

   // One key schedule update: rotate, S-box on the top nibble(s), XOR in the round counter
   function automatic key_type schedule_step(input key_type k, input logic wide,
                                              input logic [4:0] ctr, input logic [63:0] tbl);
      logic [79:0]  r80;
      logic [127:0] r128;
      r80              = {k[18:0], k[79:19]};
      r80[79:76]       = sbox_lookup(tbl, r80[79:76]);
      r80[19:15]       = r80[19:15] ^ ctr;
      r128             = {k[66:0], k[127:67]};
      r128[127:124]    = sbox_lookup(tbl, r128[127:124]);
      r128[123:120]    = sbox_lookup(tbl, r128[123:120]);
      r128[66:62]      = r128[66:62] ^ ctr;
      return wide ? r128 : {48'd0, r80};
   endfunction

endpackage

### rtl/core/present_round_key_expander.sv
`timescale 1ns / 1ps

// PRESENT round key expander.
// Key bytes arrive on the req_ channel, most significant first, one transfer per
// cycle while req_stall is low; req_final_byte marks the last byte of a key.
// In the 80-bit and 128-bit modes the bytes shift into a 128-bit key register;
// in independent mode every eight bytes form one round key held in a 32-entry store.
// After the final byte req_stall stays high until the run is delivered on rsp_:
// round_count+1 round keys, or one error result (status 1, key 0) when the byte
// count does not fit the mode. The final byte transfer moves the sequencer into its
// emit state, from which one result per cycle is registered unless a result is stalled:
// the schedule unit performs one rotate/S-box/counter update per cycle, and in
// independent mode the store's one registered read port supplies one key per cycle.
// While a valid result is held by rsp_stall, the result and the schedule state hold.
// Configuration goes through csr_write/csr_index/csr_data and takes effect at once.
// Reset (synchronous) clears the key register, byte counter and output valid and
// restores the configuration defaults; the key store is not cleared.
module present_round_key_expander
   import prke_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_key_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_round_key,
   output logic [4:0]  rsp_key_index,
   output logic        rsp_status,
   output logic        rsp_end_of_keys,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   // Configuration
   logic [1:0]  mode_ff;
   logic [4:0]  rounds_ff;
   logic [63:0] sbox_ff;

   // Run state
   logic        state_ff, state_in;
   key_type     key_ff, key_in;
   logic [8:0]  count_ff, count_in;
   logic [4:0]  idx_ff, idx_in;
   logic        err_ff, err_in;

   // Key store
   logic [63:0]         store_mem [MAX_ROUND_KEYS];
   logic [63:0]         rd_ff;
   logic                store_we;
   logic [STORE_AW-1:0] store_waddr;
   logic [STORE_AW-1:0] store_raddr;
   logic [63:0]         store_wdata;
   logic [5:0]          grp_cur;
   logic [5:0]          grp_next;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_key_ff, rsp_key_in;
   logic [4:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_status_ff, rsp_status_in;
   logic        rsp_end_ff, rsp_end_in;

   // Helpers
   logic        req_xfer;
   logic [8:0]  count_inc;
   logic [5:0]  nkeys;
   logic [8:0]  expect_len;
   logic        len_ok;
   logic        out_free;
   logic        last_key;
   logic        emit_go;

   assign req_stall       = (state_ff != ST_IDLE);
   assign req_xfer        = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_round_key   = rsp_key_ff;
   assign rsp_key_index   = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_end_of_keys = rsp_end_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         rounds_ff <= ROUNDS_RESET;
         sbox_ff   <= SBOX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[1:0];
            CSR_ROUNDS: rounds_ff <= csr_data[4:0];
            CSR_SBOX:   sbox_ff   <= csr_data;
            default:    ;
         endcase
      end
   end

   // Length check on the final byte
   always_comb begin
      count_inc = (count_ff != COUNT_MAX) ? count_ff + 9'd1 : count_ff;
      nkeys     = {1'b0, rounds_ff} + 6'd1;
      case (mode_ff)
         MODE_K80:  expect_len = 9'd10;
         MODE_K128: expect_len = 9'd16;
         default:   expect_len = {nkeys, 3'b000};
      endcase
      len_ok = (mode_ff != MODE_UNKNOWN) && (count_inc == expect_len)
               && !((mode_ff == MODE_INDEP) && (int'(nkeys) > MAX_ROUND_KEYS));
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_key = err_ff || (idx_ff == rounds_ff);
   assign emit_go  = (state_ff == ST_EMIT) && out_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (mode_ff != MODE_INDEP) begin
                  key_in = {key_ff[119:0], req_key_byte};
               end
               count_in = count_inc;
               if (req_final_byte) begin
                  state_in = ST_EMIT;
                  idx_in   = 5'd0;
                  err_in   = !len_ok;
                  count_in = 9'd0;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (last_key) begin
                  state_in = ST_IDLE;
                  key_in   = '0;
                  idx_in   = 5'd0;
               end else begin
                  idx_in = idx_ff + 5'd1;
                  key_in = schedule_step(key_ff, mode_ff == MODE_K128, idx_ff + 5'd1, sbox_ff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff   <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         err_ff   <= err_in;
      end
   end

   // Key store: byte-wise read-modify-write, registered read with write bypass
   assign grp_cur     = count_ff[8:3];
   assign grp_next    = count_in[8:3];
   assign store_we    = req_xfer && (mode_ff == MODE_INDEP)
                        && (int'(grp_cur) < MAX_ROUND_KEYS);
   assign store_waddr = STORE_AW'(grp_cur);
   assign store_wdata = {rd_ff[55:0], req_key_byte};
   assign store_raddr = (state_in == ST_EMIT) ? STORE_AW'(idx_in) : STORE_AW'(grp_next);

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we && (store_waddr == store_raddr)) begin
         rd_ff <= store_wdata;
      end else begin
         rd_ff <= store_mem[store_raddr];
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;
      if (emit_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = err_ff;
         rsp_end_in    = last_key;
         rsp_idx_in    = err_ff ? 5'd0 : idx_ff;
         if (err_ff) begin
            rsp_key_in = '0;
         end else if (mode_ff == MODE_INDEP) begin
            rsp_key_in = rd_ff;
         end else if (mode_ff == MODE_K128) begin
            rsp_key_in = key_ff[127:64];
         end else begin
            rsp_key_in = key_ff[79:16];
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff    <= rsp_key_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_end_ff    <= rsp_end_in;
   end

`ifndef ASSERT_OFF
   // An error result carries a zero key and closes the run
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_end_ff && (rsp_key_ff == 64'd0)))
      else $error("error result malformed");

   // The key index never runs past the round count
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !err_ff) |-> (idx_ff <= rounds_ff))
      else $error("key index beyond round count");

   // A stalled result holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_key_ff)
                                       && $stable(rsp_idx_ff) && $stable(rsp_end_ff)))
      else $error("stalled result changed");

   // Leaving the emit phase leaves a clean key register and counter
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=> (count_ff == 9'd0 && key_ff == '0))
      else $error("run state not cleared");
`endif

endmodule

### sim/present_round_key_expander_tb.sv
`timescale 1ns / 1ps

module present_round_key_expander_tb;
   import prke_pkg::*;

   localparam int KEY_RANDOM      = -1;
   localparam int SETTLE_CYCLES   = 8;
   localparam int QUIET_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PRINT_LIMIT     = 60;

   typedef struct packed {
      logic [63:0] round_key;
      logic [4:0]  key_index;
      logic        status;
      logic        end_of_keys;
   } round_key_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_key_byte = 8'd0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_round_key;
   logic [4:0]  rsp_key_index;
   logic        rsp_status;
   logic        rsp_end_of_keys;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_MODE;
   logic [63:0] csr_data = 64'd0;

   // Shadow copy of the configuration and of the key state
   logic [1:0]   cfg_mode = MODE_RESET;
   logic [4:0]   cfg_rounds = ROUNDS_RESET;
   logic [63:0]  cfg_sbox = SBOX_RESET;
   logic [127:0] key_shift = '0;
   logic [8:0]   bytes_taken = '0;
   logic [63:0]  supplied_keys [MAX_ROUND_KEYS] = '{default: '0};

   round_key_result_type pending_keys [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_off_req = 1'b0;
   int  hold_off_left = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;

   present_round_key_expander dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_byte    (req_key_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_round_key   (rsp_round_key),
      .rsp_key_index   (rsp_key_index),
      .rsp_status      (rsp_status),
      .rsp_end_of_keys (rsp_end_of_keys),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [3:0] substitute(input logic [3:0] x);
      return cfg_sbox[4 * int'(x) +: 4];
   endfunction

   // Take one key byte; on the final byte queue the whole run of round keys, or one error result
   function automatic void absorb_key_byte(input logic [7:0] b, input logic last);
      int           need;
      logic         ok;
      logic [127:0] k;
      logic [63:0]  rk;
      if (cfg_mode == MODE_INDEP) begin
         if (bytes_taken[8:3] < MAX_ROUND_KEYS)
            supplied_keys[bytes_taken[7:3]] = {supplied_keys[bytes_taken[7:3]][55:0], b};
      end else begin
         key_shift = {key_shift[119:0], b};
      end
      if (bytes_taken != COUNT_MAX) bytes_taken++;
      if (!last) return;

      case (cfg_mode)
         MODE_K80:  need = 10;
         MODE_K128: need = 16;
         default:   need = 8 * (int'(cfg_rounds) + 1);
      endcase
      ok = cfg_mode != MODE_UNKNOWN && int'(bytes_taken) == need;
      if (cfg_mode == MODE_INDEP && int'(cfg_rounds) + 1 > MAX_ROUND_KEYS) ok = 1'b0;

      k = key_shift;
      if (!ok) begin
         pending_keys.push_back(round_key_result_type'{64'd0, 5'd0, 1'b1, 1'b1});
      end else begin
         for (int i = 0; i <= int'(cfg_rounds); i++) begin
            case (cfg_mode)
               MODE_INDEP: rk = supplied_keys[i];
               MODE_K128:  rk = k[127:64];
               default:    rk = k[79:16];
            endcase
            pending_keys.push_back(round_key_result_type'{rk, 5'(i), 1'b0,
                                                          i == int'(cfg_rounds)});
            if (cfg_mode == MODE_K128) begin
               // rotate by 61, S-box on the top two nibbles, counter at 66..62
               k = (k << 61) | (k >> 67);
               k[127:124] = substitute(k[127:124]);
               k[123:120] = substitute(k[123:120]);
               k[66:62] = k[66:62] ^ 5'(i + 1);
            end else begin
               // 80-bit register: rotate by 61, S-box on the top nibble, counter at 19..15
               k[79:0] = (k[79:0] << 61) | (k[79:0] >> 19);
               k[79:76] = substitute(k[79:76]);
               k[19:15] = k[19:15] ^ 5'(i + 1);
            end
         end
      end
      key_shift = '0;
      bytes_taken = '0;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_key_byte(input logic [7:0] b, input logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_byte <= b;
      req_final_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_key_byte(b, last);
   endtask

   task automatic send_key(input int len, input int fill);
      for (int n = 1; n <= len; n++)
         send_key_byte(fill == KEY_RANDOM ? 8'($urandom) : 8'(fill), n == len);
   endtask

   // Sender pauses until every queued round key has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers change only with the block idle
   task automatic configure(input logic [1:0] mode, input logic [4:0] rounds,
                            input logic [63:0] sbox);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_MODE;
      csr_data <= 64'(mode);
      @(posedge clock);
      csr_index <= CSR_ROUNDS;
      csr_data <= 64'(rounds);
      @(posedge clock);
      csr_index <= CSR_SBOX;
      csr_data <= sbox;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_mode = mode;
      cfg_rounds = rounds;
      cfg_sbox = sbox;
   endtask

   // Mostly keys of the right length for the mode, some of random length
   task automatic send_random_keys(input int byte_budget);
      int sent;
      int len;
      int need;
      sent = 0;
      while (sent < byte_budget) begin
         case (cfg_mode)
            MODE_K80:  need = 10;
            MODE_K128: need = 16;
            default:   need = 8 * (int'(cfg_rounds) + 1);
         endcase
         len = ($urandom_range(99) < 85) ? need : $urandom_range(1, 24);
         send_key(len, KEY_RANDOM);
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Reset configuration: 80-bit schedule, 31 rounds, default S-box
   task automatic test_reset_settings();
      send_key(10, 'hFF);
   endtask

   // Extremes of rounds and S-box, zero rounds in the 128-bit and independent modes
   task automatic test_config_extremes();
      configure(MODE_K128, 5'd0, 64'd0);
      send_key(16, 'h00);
      configure(MODE_INDEP, 5'd0, '1);
      send_key(8, KEY_RANDOM);
      configure(MODE_K128, 5'd31, '1);
      send_key(16, KEY_RANDOM);
   endtask

   // Wrong lengths and the unknown mode each give one error result
   task automatic test_length_errors();
      configure(MODE_K80, 5'd5, SBOX_RESET);
      send_key(1, KEY_RANDOM);
      send_key(11, KEY_RANDOM);
      configure(MODE_INDEP, 5'd1, SBOX_RESET);
      send_key(15, KEY_RANDOM);
      configure(MODE_UNKNOWN, 5'd5, SBOX_RESET);
      send_key(10, KEY_RANDOM);
   endtask

   // Groups past the expected count, then a correct run over the same store
   task automatic test_store_limits();
      configure(MODE_INDEP, 5'd1, {$urandom, $urandom});
      send_key(24, KEY_RANDOM);
      send_key(16, KEY_RANDOM);
   endtask

   // Receiver holds off while a second key waits on req_stall, then the sender waits for the drain
   task automatic test_back_pressure();
      configure(MODE_K80, 5'd31, {$urandom, $urandom});
      hold_off_req = 1'b1;
      repeat (2) send_key(10, KEY_RANDOM);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int         idle_set [4] = '{0, 88, 0, 15};
      int         stall_set [4] = '{0, 0, 88, 15};
      logic [1:0] mode;
      logic [4:0] rounds;
      logic [63:0] sbox;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         mode = 2'($urandom_range(0, 2));
         rounds = (mode == MODE_INDEP) ? 5'($urandom_range(0, 3))
                                       : 5'($urandom_range(0, 31));
         case ($urandom_range(0, 3))
            0:       sbox = 64'd0;
            1:       sbox = '1;
            default: sbox = {$urandom, $urandom};
         endcase
         configure(mode, rounds, sbox);
         send_random_keys(12);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // ---------------------------------------------------------------- receiver

   // Random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin : receiver
      if (hold_off_req) begin
         hold_off_left = HOLD_OFF_CYCLES;
         hold_off_req = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      round_key_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_keys.size() == 0) begin
            report_mismatch("round key with none pending", rsp_round_key, 64'd0);
         end else begin
            want = pending_keys.pop_front();
            if (rsp_round_key !== want.round_key)
               report_mismatch("round_key", rsp_round_key, want.round_key);
            if (rsp_key_index !== want.key_index)
               report_mismatch("key_index", 64'(rsp_key_index), 64'(want.key_index));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_end_of_keys !== want.end_of_keys)
               report_mismatch("end_of_keys", 64'(rsp_end_of_keys), 64'(want.end_of_keys));
         end
      end
   end

   // Cycles without any transfer on either channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("present_round_key_expander_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : run
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_config_extremes();
      test_length_errors();
      test_store_limits();
      test_back_pressure();
      test_random_traffic();
      wait_drained();
      if (mismatches == 0) begin
         $display("present_round_key_expander_tb: clean");
      end else begin
         $display("present_round_key_expander_tb: errors");
      end
      $finish;
   end

endmodule
